FILE: hdl/command_frame_parser_unit_defines.svh
// Assertion macros for the command frame parser.
`ifndef COMMAND_FRAME_PARSER_UNIT_DEFINES_SVH
`define COMMAND_FRAME_PARSER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

`define CFP_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

`define CFP_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define CFP_ASSERT(lbl, clk, rst, prop, msg)

`define CFP_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

FILE: hdl/cfp_pkg.sv
package cfp_pkg;

   localparam int unsigned BYTE_W    = 8;
   localparam int unsigned PAYLOAD_W = 32;
   localparam int unsigned ACK_W     = 3;

   localparam logic [BYTE_W-1:0] HDR_FIRST  = 8'h23;
   localparam logic [BYTE_W-1:0] HDR_SECOND = 8'h02;
   localparam logic [BYTE_W-1:0] FRAME_TAIL = 8'hAA;
   localparam logic [BYTE_W-1:0] FLAG_ON    = 8'h31;
   localparam logic [BYTE_W-1:0] FLAG_OFF   = 8'h30;

   typedef enum logic [8:0] {
      PH_HUNT = 9'b000000001,
      PH_HDR2 = 9'b000000010,
      PH_CMD  = 9'b000000100,
      PH_PL0  = 9'b000001000,
      PH_PL1  = 9'b000010000,
      PH_PL2  = 9'b000100000,
      PH_PL3  = 9'b001000000,
      PH_FLAG = 9'b010000000,
      PH_TAIL = 9'b100000000
   } phase_type;

   typedef struct packed {
      phase_type                phase;
      logic [BYTE_W-1:0]        command;
      logic [PAYLOAD_W-1:0]     payload;
      logic [BYTE_W-1:0]        run_flag;
   } parse_state_type;

   typedef struct packed {
      logic                     emit;
      logic [BYTE_W-1:0]        command;
      logic [PAYLOAD_W-1:0]     payload;
      logic [BYTE_W-1:0]        run_flag;
      logic [ACK_W-1:0]         ack_code;
      logic                     update_request;
   } frame_result_type;

endpackage

FILE: hdl/command_frame_parser_unit.sv
// Channel   Direction  Handshake            Payload
// req       in         req_valid/req_ready  req_rx_byte[7:0]
// rsp       out        rsp_valid/rsp_ready  command, payload, run_flag, ack_code,
//                                           update_request
//
// One byte per cycle while req_ready is high; a result appears in the cycle
// after its tail byte is taken, from the result register.
// Synchronous reset returns to header hunt; all but the result register clear.
// req_ready drops only when a tail byte is due and the result register is
// full and not being taken; all other bytes pass during an output stall.
`include "command_frame_parser_unit_defines.svh"

module command_frame_parser_unit (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [cfp_pkg::BYTE_W-1:0]       req_rx_byte,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [cfp_pkg::BYTE_W-1:0]       rsp_command,
   output logic [cfp_pkg::PAYLOAD_W-1:0]    rsp_payload,
   output logic [cfp_pkg::BYTE_W-1:0]       rsp_run_flag,
   output logic [cfp_pkg::ACK_W-1:0]        rsp_ack_code,
   output logic                             rsp_update_request
);

   cfp_pkg::parse_state_type  state_ff, state_in;
   cfp_pkg::frame_result_type step_result;
   cfp_pkg::frame_result_type result_ff, result_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      req_take;
   logic                      load;

   cfp_frame_step u_step (
      .state_cur (state_ff),
      .rx_byte   (req_rx_byte),
      .state_nxt (state_in),
      .result    (step_result)
   );

   assign req_ready = !rsp_valid_ff || rsp_ready || (state_ff.phase != cfp_pkg::PH_TAIL);
   assign req_take  = req_valid && req_ready;
   assign load      = req_take && step_result.emit;

   assign result_in    = load ? step_result : result_ff;
   assign rsp_valid_in = load || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.phase    <= cfp_pkg::PH_HUNT;
         state_ff.command  <= '0;
         state_ff.payload  <= '0;
         state_ff.run_flag <= '0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         if (req_take) begin
            state_ff <= state_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      result_ff <= result_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_command        = result_ff.command;
   assign rsp_payload        = result_ff.payload;
   assign rsp_run_flag       = result_ff.run_flag;
   assign rsp_ack_code       = result_ff.ack_code;
   assign rsp_update_request = result_ff.update_request;

   `CFP_ASSERT_NEXT(a_tail_loads, clock, reset, req_valid && req_ready && (state_ff.phase == cfp_pkg::PH_TAIL) && (req_rx_byte == cfp_pkg::FRAME_TAIL), rsp_valid, "good tail did not load a result")
   `CFP_ASSERT(a_stall_only_tail, clock, reset, !req_ready |-> (rsp_valid && (state_ff.phase == cfp_pkg::PH_TAIL)), "input stalled outside a full tail slot")
   `CFP_ASSERT_NEXT(a_result_kept, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload) && $stable(rsp_command), "waiting result lost or changed")
   `CFP_ASSERT_NEXT(a_no_phantom, clock, reset, !rsp_valid && !(req_valid && req_ready && (state_ff.phase == cfp_pkg::PH_TAIL)), !rsp_valid, "result without a tail byte")

endmodule

FILE: hdl/cfp_frame_step.sv
module cfp_frame_step (
   input  cfp_pkg::parse_state_type      state_cur,
   input  logic [cfp_pkg::BYTE_W-1:0]    rx_byte,
   output cfp_pkg::parse_state_type      state_nxt,
   output cfp_pkg::frame_result_type     result
);

   always_comb begin
      state_nxt = state_cur;
      case (state_cur.phase)
         cfp_pkg::PH_HDR2: begin
            state_nxt.phase = (rx_byte == cfp_pkg::HDR_SECOND) ? cfp_pkg::PH_CMD
                                                                : cfp_pkg::PH_HUNT;
         end
         cfp_pkg::PH_CMD: begin
            state_nxt.command = rx_byte;
            state_nxt.phase   = cfp_pkg::PH_PL0;
         end
         cfp_pkg::PH_PL0: begin
            state_nxt.payload[7:0] = rx_byte;
            state_nxt.phase        = cfp_pkg::PH_PL1;
         end
         cfp_pkg::PH_PL1: begin
            state_nxt.payload[15:8] = rx_byte;
            state_nxt.phase         = cfp_pkg::PH_PL2;
         end
         cfp_pkg::PH_PL2: begin
            state_nxt.payload[23:16] = rx_byte;
            state_nxt.phase          = cfp_pkg::PH_PL3;
         end
         cfp_pkg::PH_PL3: begin
            state_nxt.payload[31:24] = rx_byte;
            state_nxt.phase          = cfp_pkg::PH_FLAG;
         end
         cfp_pkg::PH_FLAG: begin
            if (rx_byte inside {cfp_pkg::FLAG_ON, cfp_pkg::FLAG_OFF}) begin
               state_nxt.run_flag = rx_byte;
            end
            state_nxt.phase = cfp_pkg::PH_TAIL;
         end
         cfp_pkg::PH_TAIL: begin
            state_nxt.phase = cfp_pkg::PH_HUNT;
         end
         default: begin
            state_nxt.phase = (rx_byte == cfp_pkg::HDR_FIRST) ? cfp_pkg::PH_HDR2
                                                               : cfp_pkg::PH_HUNT;
         end
      endcase
   end

   always_comb begin
      result.emit     = (state_cur.phase == cfp_pkg::PH_TAIL) &&
                        (rx_byte == cfp_pkg::FRAME_TAIL);
      result.command  = state_cur.command;
      result.payload  = state_cur.payload;
      result.run_flag = state_cur.run_flag;
      result.ack_code = (state_cur.command inside {[8'd1:8'd5]}) ?
                        state_cur.command[cfp_pkg::ACK_W-1:0] : '0;
      result.update_request = state_cur.command inside {[8'd3:8'd5]};
   end

endmodule

FILE: tb/command_frame_checker.sv
module command_frame_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_ready,
   input  logic [cfp_pkg::BYTE_W-1:0]    req_rx_byte,
   input  logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  logic [cfp_pkg::BYTE_W-1:0]    rsp_command,
   input  logic [cfp_pkg::PAYLOAD_W-1:0] rsp_payload,
   input  logic [cfp_pkg::BYTE_W-1:0]    rsp_run_flag,
   input  logic [cfp_pkg::ACK_W-1:0]     rsp_ack_code,
   input  logic                          rsp_update_request,
   output int                            mismatches,
   output int                            frames_pending,
   output int                            frames_checked,
   output int                            gait_updates
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [cfp_pkg::BYTE_W-1:0]    command;
      logic [cfp_pkg::PAYLOAD_W-1:0] payload;
      logic [cfp_pkg::BYTE_W-1:0]    run_flag;
      logic [cfp_pkg::ACK_W-1:0]     ack_code;
      logic                          update_request;
   } frame_word_type;

   cfp_pkg::phase_type            phase;
   logic [cfp_pkg::BYTE_W-1:0]    command_held;
   logic [cfp_pkg::PAYLOAD_W-1:0] payload_held;
   logic [cfp_pkg::BYTE_W-1:0]    run_flag_held;
   frame_word_type                frames_due[$];

   task automatic report(input string what, input logic [31:0] got,
                         input logic [31:0] want);
      $display("%0t: frame %0d %s: got 0x%0h, expected 0x%0h",
               $realtime, frames_checked, what, got, want);
      mismatches++;
   endtask

   // Advance the frame search by one received byte; queue a frame on a good tail.
   function automatic void parse_byte(input logic [cfp_pkg::BYTE_W-1:0] b);
      frame_word_type f;
      case (phase)
         cfp_pkg::PH_HDR2: phase = (b == cfp_pkg::HDR_SECOND) ? cfp_pkg::PH_CMD
                                                              : cfp_pkg::PH_HUNT;
         cfp_pkg::PH_CMD: begin
            command_held = b;
            phase = cfp_pkg::PH_PL0;
         end
         cfp_pkg::PH_PL0: begin
            payload_held[7:0] = b;
            phase = cfp_pkg::PH_PL1;
         end
         cfp_pkg::PH_PL1: begin
            payload_held[15:8] = b;
            phase = cfp_pkg::PH_PL2;
         end
         cfp_pkg::PH_PL2: begin
            payload_held[23:16] = b;
            phase = cfp_pkg::PH_PL3;
         end
         cfp_pkg::PH_PL3: begin
            payload_held[31:24] = b;
            phase = cfp_pkg::PH_FLAG;
         end
         cfp_pkg::PH_FLAG: begin
            // flag is taken even if the tail later turns out bad
            if (b == cfp_pkg::FLAG_ON || b == cfp_pkg::FLAG_OFF) run_flag_held = b;
            phase = cfp_pkg::PH_TAIL;
         end
         cfp_pkg::PH_TAIL: begin
            phase = cfp_pkg::PH_HUNT;
            if (b == cfp_pkg::FRAME_TAIL) begin
               f.command        = command_held;
               f.payload        = payload_held;
               f.run_flag       = run_flag_held;
               f.ack_code       = (command_held >= 8'd1 && command_held <= 8'd5) ?
                                  command_held[cfp_pkg::ACK_W-1:0] : '0;
               f.update_request = (command_held >= 8'd3 && command_held <= 8'd5);
               frames_due.push_back(f);
            end
         end
         default: phase = (b == cfp_pkg::HDR_FIRST) ? cfp_pkg::PH_HDR2 : cfp_pkg::PH_HUNT;
      endcase
   endfunction

   always @(posedge clock) begin
      frame_word_type want;
      if (reset) begin
         phase          = cfp_pkg::PH_HUNT;
         command_held   = '0;
         payload_held   = '0;
         run_flag_held  = '0;
         mismatches     = 0;
         frames_checked = 0;
         gait_updates   = 0;
         frames_due.delete();
      end else begin
         // results first: a word leaving now never belongs to a byte arriving now
         if (rsp_valid && rsp_ready) begin
            if (frames_due.size() == 0) begin
               report("unexpected word", 32'(rsp_command), 32'd0);
            end else begin
               want = frames_due.pop_front();
               if (rsp_command !== want.command)
                  report("command", 32'(rsp_command), 32'(want.command));
               if (rsp_payload !== want.payload)
                  report("payload", rsp_payload, want.payload);
               if (rsp_run_flag !== want.run_flag)
                  report("run_flag", 32'(rsp_run_flag), 32'(want.run_flag));
               if (rsp_ack_code !== want.ack_code)
                  report("ack_code", 32'(rsp_ack_code), 32'(want.ack_code));
               if (rsp_update_request !== want.update_request)
                  report("update_request", 32'(rsp_update_request),
                         32'(want.update_request));
               if (want.update_request) gait_updates++;
               frames_checked++;
            end
         end
         if (req_valid && req_ready) parse_byte(req_rx_byte);
      end
      frames_pending = frames_due.size();
   end

endmodule

FILE: tb/tb_command_frame_parser_unit.sv
module tb_command_frame_parser_unit;
   timeunit 1ns;
   timeprecision 1ps;

   typedef logic [cfp_pkg::BYTE_W-1:0]    byte_type;
   typedef logic [cfp_pkg::PAYLOAD_W-1:0] word_type;

   localparam int BYTE_TARGET = 1200;
   localparam int IDLE_PCT    = 16;
   localparam int STALL_LIMIT = 2000;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_ready;
   byte_type                     req_rx_byte = '0;
   logic                         rsp_valid;
   logic                         rsp_ready = 1'b0;
   byte_type                     rsp_command;
   word_type                     rsp_payload;
   byte_type                     rsp_run_flag;
   logic [cfp_pkg::ACK_W-1:0]    rsp_ack_code;
   logic                         rsp_update_request;

   int   mismatches;
   int   frames_pending;
   int   frames_checked;
   int   gait_updates;
   int   bytes_sent = 0;
   int   quiet_cycles = 0;
   logic steady = 1'b0;
   bit   drained_mid = 1'b0;

   always #6 clock = ~clock;

   command_frame_parser_unit DUT (.*);

   command_frame_checker frame_check (.*);

   always @(posedge clock) begin
      rsp_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $realtime, quiet_cycles);
            $display("CHECK FAILED");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   task automatic send_byte(input byte_type b);
      while (!steady && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      bytes_sent++;
   endtask

   task automatic send_frame(input byte_type cmd, input word_type word,
                             input byte_type flag, input byte_type tail);
      send_byte(cfp_pkg::HDR_FIRST);
      send_byte(cfp_pkg::HDR_SECOND);
      send_byte(cmd);
      for (int i = 0; i < 4; i++) send_byte(word[8*i +: 8]);
      send_byte(flag);
      send_byte(tail);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (frames_pending != 0);
   endtask

   task automatic random_burst();
      int       pick;
      int       roll;
      byte_type cmd;
      word_type word;
      byte_type flag;
      pick = $urandom_range(99);
      cmd  = ($urandom_range(9) < 7) ? byte_type'($urandom_range(6)) : byte_type'($urandom);
      roll = $urandom_range(9);
      word = (roll == 0) ? '0 : (roll == 1) ? '1 : word_type'($urandom);
      roll = $urandom_range(9);
      flag = (roll < 4) ? cfp_pkg::FLAG_ON : (roll < 8) ? cfp_pkg::FLAG_OFF
                                                         : byte_type'($urandom);
      if (pick < 75) begin
         send_frame(cmd, word, flag, cfp_pkg::FRAME_TAIL);
      end else if (pick < 85) begin
         send_frame(cmd, word, flag, byte_type'($urandom));
      end else if (pick < 92) begin
         send_byte(cfp_pkg::HDR_FIRST);
         send_byte(byte_type'($urandom));
      end else begin
         send_byte(byte_type'($urandom));
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_frame(8'd3, 32'h0000_0000, cfp_pkg::FLAG_ON, cfp_pkg::FRAME_TAIL);
      // stray byte, then a header that restarts on a wrong second byte
      send_byte(cfp_pkg::HDR_SECOND);
      send_byte(cfp_pkg::HDR_FIRST);
      send_byte(cfp_pkg::HDR_FIRST);
      // bad tail, but the '0' flag sticks
      send_frame(8'hFF, 32'hFFFF_FFFF, cfp_pkg::FLAG_OFF, 8'h00);
      // unlisted command, flag byte ignored
      send_frame(8'd0, 32'hFFFF_FFFF, 8'hFF, cfp_pkg::FRAME_TAIL);
      drain();

      while (bytes_sent < BYTE_TARGET) begin
         steady <= (bytes_sent >= 400 && bytes_sent < 700);
         if (!drained_mid && bytes_sent >= 800) begin
            drain();
            drained_mid = 1'b1;
         end
         random_burst();
      end
      drain();
      repeat (10) @(posedge clock);

      $display("Sent %0d bytes of frames, broken frames and noise; %0d frames checked,",
               bytes_sent, frames_checked);
      $display("%0d with update requests, under random stalls on both sides.", gait_updates);
      if (mismatches == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

FILE: command_frame_parser_unit.f
+incdir+hdl
hdl/cfp_pkg.sv
hdl/cfp_frame_step.sv
hdl/command_frame_parser_unit.sv
tb/command_frame_checker.sv
tb/tb_command_frame_parser_unit.sv
